>>> hdl/lrast_pkg.sv
`timescale 1ns / 1ps

package lrast_pkg;

    // command codes carried in s_axis_tuser
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // fixed field widths
    localparam int unsigned POS_IN_W = 10;
    localparam int unsigned VAL_W    = 16;
    localparam int unsigned SUM_W    = 48;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } lrast_state_t;

endpackage

>>> hdl/lazy_range_add_sum_tree_top.sv
`timescale 1ns / 1ps
// lazy range-add / range-sum segment tree over NUM_POSITIONS positions
// input channel s_axis: one transaction is one command; tuser selects add (0)
// or query (1), tdata carries the inclusive range and the signed add amount
// output channel m_axis: exactly one transaction per command; tdata is the
// range sum (zero for an add or a bad range), tuser holds the bad-range flag
// and the sticky node-overflow flag
// each command walks the tree held in one ram (sum and pending tag per node);
// every visited node goes through a read, a multiply and an update/write-back state;
// a walk visits at most about 4*log2(NUM_POSITIONS) nodes, between an accept
// step and a result step; a bad range skips the walk and goes straight from
// accept to result
// one command is in flight at a time; the ram read port sets the pace
// after reset a clearing pass zeroes all 4*NUM_POSITIONS ram entries, with
// s_axis_tready low; the overflow flag clears at reset and, once set, stays set
// the result sits in an output register; while the receiver stalls, the next
// command is still accepted and walked, and it waits only to hand its result
// over until the register frees up

module lazy_range_add_sum_tree_top #(
    parameter int unsigned NUM_POSITIONS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // range_low[9:0], range_high[19:10], add_value[35:20]
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // range_sum[47:0]
    output logic [1:0]  m_axis_tuser    // bad_range[0], overflow_seen[1]
);

    localparam int unsigned PW    = $clog2(NUM_POSITIONS);   // position width
    localparam int unsigned CW    = PW + 1;                   // overlap count width
    localparam int unsigned DEPTH = 4 * NUM_POSITIONS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned SD    = PW + 1;                   // stack entries
    localparam int unsigned SIW   = $clog2(SD);
    localparam int unsigned SPW   = $clog2(SD + 1);
    localparam int unsigned TW    = lrast_pkg::SUM_W;
    localparam int unsigned VW    = lrast_pkg::VAL_W;
    localparam int unsigned IW    = lrast_pkg::POS_IN_W;
    localparam logic [16:0]   NPOS     = 17'(NUM_POSITIONS);
    localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROOT     = AW'(1);
    localparam logic [PW-1:0] TOP_POS  = PW'(NUM_POSITIONS - 1);

    typedef struct packed {
        logic [AW-1:0] k;
        logic [PW-1:0] lo;
        logic [PW-1:0] hi;
        logic [PW-1:0] a;
        logic [PW-1:0] b;
    } walk_t;

    // input field split
    logic [IW-1:0]       in_low;
    logic [IW-1:0]       in_high;
    logic signed [VW-1:0] in_value;
    logic                in_bad;

    assign in_low   = s_axis_tdata[9:0];
    assign in_high  = s_axis_tdata[19:10];
    assign in_value = $signed(s_axis_tdata[35:20]);
    assign in_bad   = (in_low > in_high) || (17'(in_high) >= NPOS);

    // control registers
    lrast_pkg::lrast_state_t state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic           ovf_reg, ovf_next;
    logic           out_valid_reg, out_valid_next;

    // payload registers
    walk_t                cur_reg, cur_next;
    logic                 cmd_reg, cmd_next;
    logic signed [VW-1:0] v_reg, v_next;
    logic                 bad_reg, bad_next;
    logic [TW-1:0]        acc_reg, acc_next;
    logic [TW-1:0]        tot_reg, tot_next;
    logic [TW-1:0]        tag_reg, tag_next;
    logic [TW-1:0]        prod_reg, prod_next;
    logic [TW-1:0]        out_sum_reg, out_sum_next;
    logic                 out_bad_reg, out_bad_next;
    logic                 out_ovf_reg, out_ovf_next;
    walk_t                stack_reg [SD];

    // ram port
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [2*TW-1:0] ram_wdata, ram_rdata;

    lrast_ram #(
        .WIDTH (2 * TW),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // node arithmetic
    logic [CW-1:0]           cnt;
    logic [TW+CW-1:0]        qmul;
    logic signed [VW+CW:0]   amul;
    logic [TW:0]             tot_sum;
    logic [TW:0]             tag_sum;
    logic                    full_cover;
    logic                    leaf;
    logic [PW:0]             mid_sum;
    logic [PW-1:0]           mid;
    logic [PW-1:0]           mid_p1;
    logic [AW-1:0]           kl;
    logic [AW-1:0]           kr;
    logic [SPW-1:0]          sp_dec;
    logic                    push;
    walk_t                   push_ent;

    assign cnt     = CW'(cur_reg.b) - CW'(cur_reg.a) + CW'(1);
    assign qmul    = {{CW{1'b0}}, ram_rdata[2*TW-1:TW]} * {{TW{1'b0}}, cnt};
    assign amul    = v_reg * $signed({1'b0, cnt});
    assign tot_sum = {tot_reg[TW-1], tot_reg} + {prod_reg[TW-1], prod_reg};
    assign tag_sum = {tag_reg[TW-1], tag_reg} + (TW+1)'(v_reg);

    assign full_cover = (cur_reg.a == cur_reg.lo) && (cur_reg.b == cur_reg.hi);
    assign leaf       = (cur_reg.lo == cur_reg.hi);
    assign mid_sum    = {1'b0, cur_reg.lo} + {1'b0, cur_reg.hi};
    assign mid        = mid_sum[PW:1];
    assign mid_p1     = mid + PW'(1);
    assign kl         = {cur_reg.k[AW-2:0], 1'b0};
    assign kr         = {cur_reg.k[AW-2:0], 1'b1};
    assign sp_dec     = sp_reg - SPW'(1);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        sp_next        = sp_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        cur_next       = cur_reg;
        cmd_next       = cmd_reg;
        v_next         = v_reg;
        bad_next       = bad_reg;
        acc_next       = acc_reg;
        tot_next       = tot_reg;
        tag_next       = tag_reg;
        prod_next      = prod_reg;
        out_sum_next   = out_sum_reg;
        out_bad_next   = out_bad_reg;
        out_ovf_next   = out_ovf_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg.k;
        ram_wdata      = {(full_cover && !leaf) ? tag_sum[TW-1:0] : tag_reg, tot_sum[TW-1:0]};
        ram_re         = 1'b0;
        ram_raddr      = cur_reg.k;
        push           = 1'b0;
        push_ent       = '{k: kr, lo: mid_p1, hi: cur_reg.hi, a: mid_p1, b: cur_reg.b};
        s_axis_tready  = 1'b0;

        unique case (state_reg)
            lrast_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_ADR)
                begin
                    state_next = lrast_pkg::ST_IDLE;
                end
            end
            lrast_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd_next = s_axis_tuser;
                    v_next   = in_value;
                    bad_next = in_bad;
                    acc_next = '0;
                    sp_next  = '0;
                    cur_next = '{k: ROOT, lo: '0, hi: TOP_POS,
                                 a: PW'(in_low), b: PW'(in_high)};
                    state_next = in_bad ? lrast_pkg::ST_DONE : lrast_pkg::ST_READ;
                end
            end
            lrast_pkg::ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = lrast_pkg::ST_MUL;
            end
            lrast_pkg::ST_MUL:
            begin
                tot_next   = ram_rdata[TW-1:0];
                tag_next   = ram_rdata[2*TW-1:TW];
                prod_next  = (cmd_reg == lrast_pkg::CMD_QUERY) ? qmul[TW-1:0] : TW'(amul);
                state_next = lrast_pkg::ST_UPD;
            end
            lrast_pkg::ST_UPD:
            begin
                if (cmd_reg == lrast_pkg::CMD_ADD)
                begin
                    ram_we = 1'b1;
                    if ((tot_sum[TW] != tot_sum[TW-1]) ||
                        (full_cover && !leaf && (tag_sum[TW] != tag_sum[TW-1])))
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    acc_next = acc_reg + (full_cover ? tot_reg : prod_reg);
                end
                if (full_cover)
                begin
                    // node done: resume a deferred right branch or finish
                    if (sp_reg == '0)
                    begin
                        state_next = lrast_pkg::ST_DONE;
                    end
                    else
                    begin
                        cur_next   = stack_reg[sp_dec[SIW-1:0]];
                        sp_next    = sp_dec;
                        state_next = lrast_pkg::ST_READ;
                    end
                end
                else
                begin
                    state_next = lrast_pkg::ST_READ;
                    if (cur_reg.b <= mid)
                    begin
                        cur_next = '{k: kl, lo: cur_reg.lo, hi: mid, a: cur_reg.a, b: cur_reg.b};
                    end
                    else if (cur_reg.a > mid)
                    begin
                        cur_next = '{k: kr, lo: mid_p1, hi: cur_reg.hi, a: cur_reg.a,
                                     b: cur_reg.b};
                    end
                    else
                    begin
                        // split: left first, right parked on the stack
                        push     = 1'b1;
                        sp_next  = sp_reg + SPW'(1);
                        cur_next = '{k: kl, lo: cur_reg.lo, hi: mid, a: cur_reg.a, b: mid};
                    end
                end
            end
            lrast_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_reg;
                    out_bad_next   = bad_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = lrast_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrast_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrast_pkg::ST_CLEAR;
            clr_reg       <= '0;
            sp_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sp_reg        <= sp_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        cmd_reg     <= cmd_next;
        v_reg       <= v_next;
        bad_reg     <= bad_next;
        acc_reg     <= acc_next;
        tot_reg     <= tot_next;
        tag_reg     <= tag_next;
        prod_reg    <= prod_next;
        out_sum_reg <= out_sum_next;
        out_bad_reg <= out_bad_next;
        out_ovf_reg <= out_ovf_next;
        if (push)
        begin
            stack_reg[sp_reg[SIW-1:0]] <= push_ent;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sum_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_bad_reg};

    // walk stack never runs past its depth
    assert property (@(posedge clk) disable iff (!rst_n) 32'(sp_reg) <= SD)
        else $error("walk stack overrun");

    // in the update state the current node holds a nonempty subrange of its span
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrast_pkg::ST_UPD) |->
        (cur_reg.lo <= cur_reg.a && cur_reg.a <= cur_reg.b && cur_reg.b <= cur_reg.hi))
        else $error("node range out of span");

    // overflow flag is sticky
    assert property (@(posedge clk) disable iff (!rst_n) !$fell(ovf_reg))
        else $error("overflow flag cleared");

    // a rejected range reports a zero sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrast_pkg::ST_DONE && bad_reg) |-> (acc_reg == '0))
        else $error("bad range with nonzero sum");

endmodule

>>> hdl/lrast_ram.sv
`timescale 1ns / 1ps

module lrast_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
